/* design/ipmd_pkg.sv */
// shared types and constants for the incremental pid motor drive
package ipmd_pkg;

    // default sizing of the top level
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int ACC_WIDTH_DEF      = 48;
    localparam int OUTPUT_LIMIT_DEF   = 255;

    // fixed field widths
    localparam int COEF_W     = 32;
    localparam int SETPOINT_W = 32;
    localparam int POS_OUT_W  = 32;
    localparam int DUTY_W     = 8;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 2;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_NOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PREV2 = 2'd2;

    // coefficient reset values, q16.16
    localparam logic signed [COEF_W-1:0] COEF_NOW_RST   = 32'sd6619464;
    localparam logic signed [COEF_W-1:0] COEF_PREV_RST  = -32'sd13172408;
    localparam logic signed [COEF_W-1:0] COEF_PREV2_RST = 32'sd6553600;

    // item kinds
    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // encoder direction pin level that counts down
    localparam logic DIR_PIN_DOWN = 1'b1;

    // drive direction codes
    typedef enum logic [1:0] {
        DRIVE_STOP    = 2'd0,
        DRIVE_FORWARD = 2'd1,
        DRIVE_REVERSE = 2'd2
    } t_drive_dir;

endpackage

/* design/ipmd_if.sv */
// channel interfaces: input items, results and configuration writes

interface ipmd_item_if;
    import ipmd_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic                         direction_level;
    logic signed [SETPOINT_W-1:0] setpoint_pulses;
    modport source (output valid, kind, direction_level, setpoint_pulses, input ready);
    modport sink   (input valid, kind, direction_level, setpoint_pulses, output ready);
endinterface

interface ipmd_result_if;
    import ipmd_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [DUTY_W-1:0]           duty;
    t_drive_dir                  drive_dir;
    logic signed [POS_OUT_W-1:0] position_now;
    modport source (output valid, duty, drive_dir, position_now, input ready);
    modport sink   (input valid, duty, drive_dir, position_now, output ready);
endinterface

interface ipmd_cfg_if;
    import ipmd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [COEF_W-1:0]    wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* design/incremental_pid_motor_drive_top.sv */
// incremental pid position loop for a dc motor with an encoder
//
// i_item carries encoder pulse beats (kind 0) and control tick beats (kind 1).
// a pulse steps the wrapping position count, down when direction_level is
// high, and gives no result. a tick forms setpoint minus position, adds the
// three weighted errors to the saturating accumulator and sends one beat on
// o_result: duty (clamped integer magnitude), drive_dir and position_now.
// i_cfg writes the three q16.16 coefficients; it is always ready and should
// only be written while the block is idle.
// a tick goes input register -> product register -> result register; a pulse
// ends in the input register. one item can be taken every cycle unless a tick
// is held there; the three products are registered before the sum.
// when the receiver stalls, the result holds in the output register and the
// product and input registers still fill, so pulses keep flowing unless a
// tick is stuck behind a full product stage.
// reset (synchronous, active low) clears position, errors, accumulator and
// all valid flags, and loads the reset coefficients.
module incremental_pid_motor_drive_top #(
    parameter int POSITION_WIDTH = ipmd_pkg::POSITION_WIDTH_DEF,
    parameter int ACC_WIDTH      = ipmd_pkg::ACC_WIDTH_DEF,
    parameter int OUTPUT_LIMIT   = ipmd_pkg::OUTPUT_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipmd_cfg_if.sink     i_cfg,
    ipmd_item_if.sink    i_item,
    ipmd_result_if.source o_result
);
    import ipmd_pkg::*;

    localparam int ERR_W  = ((POSITION_WIDTH > SETPOINT_W) ? POSITION_WIDTH : SETPOINT_W) + 1;
    localparam int PROD_W = COEF_W + ERR_W;
    localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 2;
    localparam int INT_W  = ACC_WIDTH - FRAC_BITS;
    localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    localparam logic [INT_W-1:0]     LIMIT   = INT_W'(OUTPUT_LIMIT);

    // configuration registers
    logic signed [COEF_W-1:0] r_coef_now, r_coef_prev, r_coef_prev2;

    // input stage
    logic                         r_s1_valid;
    logic                         r_s1_kind;
    logic                         r_s1_dir;
    logic signed [SETPOINT_W-1:0] r_s1_setpoint;

    // loop state
    logic signed [POSITION_WIDTH-1:0] r_pos;
    logic signed [ERR_W-1:0]          r_err1, r_err2;
    logic signed [ACC_WIDTH-1:0]      r_acc;

    // product stage
    logic                        r_s2_valid;
    logic signed [PROD_W-1:0]    r_p_now, r_p_prev, r_p_prev2;
    logic [POS_OUT_W-1:0]        r_s2_pos;

    // result stage
    logic                 r_out_valid;
    logic [DUTY_W-1:0]    r_out_duty;
    t_drive_dir           r_out_dir;
    logic [POS_OUT_W-1:0] r_out_pos;

    logic out_free, s2_free, s1_leave, s1_free, in_beat, tick_go, pulse_go, s2_go;
    logic signed [ERR_W-1:0]     c_err;
    logic signed [PROD_W-1:0]    c_p_now, c_p_prev, c_p_prev2;
    logic signed [SUM_W-1:0]     c_sum;
    logic [SUM_W-ACC_WIDTH:0]    c_sum_hi;
    logic [ACC_WIDTH-1:0]        c_acc_next;
    logic [ACC_WIDTH-1:0]        c_mag;
    logic [INT_W-1:0]            c_int;
    logic [INT_W-1:0]            c_clamp;
    t_drive_dir                  c_dir;

    // pipeline handshake, each stage moves when the next one has room
    assign out_free = !r_out_valid || o_result.ready;
    assign s2_free  = !r_s2_valid || out_free;
    assign s1_leave = r_s1_valid && ((r_s1_kind == KIND_PULSE) || s2_free);
    assign s1_free  = !r_s1_valid || s1_leave;
    assign in_beat  = i_item.valid && s1_free;
    assign tick_go  = s1_leave && (r_s1_kind == KIND_TICK);
    assign pulse_go = s1_leave && (r_s1_kind == KIND_PULSE);
    assign s2_go    = r_s2_valid && out_free;

    assign i_item.ready = s1_free;
    assign i_cfg.ready  = 1'b1;

    // coefficient writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_now   <= COEF_NOW_RST;
            r_coef_prev  <= COEF_PREV_RST;
            r_coef_prev2 <= COEF_PREV2_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                CFG_COEF_NOW:   r_coef_now   <= i_cfg.wdata;
                CFG_COEF_PREV:  r_coef_prev  <= i_cfg.wdata;
                CFG_COEF_PREV2: r_coef_prev2 <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_leave) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_kind     <= i_item.kind;
            r_s1_dir      <= i_item.direction_level;
            r_s1_setpoint <= i_item.setpoint_pulses;
        end
    end

    // error and the three weighted terms
    assign c_err     = ERR_W'(r_s1_setpoint) - ERR_W'(r_pos);
    assign c_p_now   = r_coef_now * c_err;
    assign c_p_prev  = r_coef_prev * r_err1;
    assign c_p_prev2 = r_coef_prev2 * r_err2;

    // position count and error history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_err1 <= '0;
            r_err2 <= '0;
        end else begin
            if (pulse_go) begin
                r_pos <= (r_s1_dir == DIR_PIN_DOWN) ? r_pos - POSITION_WIDTH'(1)
                                                    : r_pos + POSITION_WIDTH'(1);
            end
            if (tick_go) begin
                r_err2 <= r_err1;
                r_err1 <= c_err;
            end
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (tick_go) begin
            r_s2_valid <= 1'b1;
        end else if (s2_go) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_go) begin
            r_p_now   <= c_p_now;
            r_p_prev  <= c_p_prev;
            r_p_prev2 <= c_p_prev2;
            r_s2_pos  <= POS_OUT_W'($unsigned(r_pos));
        end
    end

    // exact sum, then saturate to the accumulator width
    assign c_sum = SUM_W'(r_acc) + SUM_W'(r_p_now) + SUM_W'(r_p_prev) + SUM_W'(r_p_prev2);
    assign c_sum_hi = c_sum[SUM_W-1:ACC_WIDTH-1];

    always_comb begin
        if ((&c_sum_hi) || !(|c_sum_hi)) begin
            c_acc_next = c_sum[ACC_WIDTH-1:0];
        end else if (c_sum[SUM_W-1]) begin
            c_acc_next = ACC_MIN;
        end else begin
            c_acc_next = ACC_MAX;
        end
    end

    // magnitude, integer part and clamp
    assign c_mag   = c_acc_next[ACC_WIDTH-1] ? (~c_acc_next + ACC_WIDTH'(1)) : c_acc_next;
    assign c_int   = c_mag[ACC_WIDTH-1:FRAC_BITS];
    assign c_clamp = (c_int > LIMIT) ? LIMIT : c_int;

    always_comb begin
        if (c_acc_next == '0) begin
            c_dir = DRIVE_STOP;
        end else if (c_acc_next[ACC_WIDTH-1]) begin
            c_dir = DRIVE_REVERSE;
        end else begin
            c_dir = DRIVE_FORWARD;
        end
    end

    // accumulator and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else if (s2_go) begin
            r_acc       <= c_acc_next;
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_duty <= c_clamp[DUTY_W-1:0];
            r_out_dir  <= c_dir;
            r_out_pos  <= r_s2_pos;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.duty         = r_out_duty;
    assign o_result.drive_dir    = r_out_dir;
    assign o_result.position_now = r_out_pos;

endmodule

/* design/ipmd_chk.sv */
// port-level checks for the incremental pid motor drive, bound to the top
module ipmd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic [ipmd_pkg::DUTY_W-1:0]          i_duty,
    input logic [1:0]                           i_drive_dir,
    input logic [ipmd_pkg::POS_OUT_W-1:0]       i_position_now
);
    import ipmd_pkg::*;

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    // stopped drive means zero duty
    a_stop_no_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_drive_dir == DRIVE_STOP)) |-> (i_duty == '0))
        else $error("nonzero duty with stopped drive");

    // a nonzero duty always carries a direction
    a_duty_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_duty != '0)) |->
            ((i_drive_dir == DRIVE_FORWARD) || (i_drive_dir == DRIVE_REVERSE)))
        else $error("duty without drive direction");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_duty) && $stable(i_drive_dir)
             && $stable(i_position_now)))
        else $error("stalled result changed");

endmodule

bind incremental_pid_motor_drive_top ipmd_chk u_ipmd_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_duty         (o_result.duty),
    .i_drive_dir    (o_result.drive_dir),
    .i_position_now (o_result.position_now)
);

/* dv/incremental_pid_motor_drive_top_test.sv */
// self-checking testbench for the incremental pid motor drive top level
`timescale 1ns / 1ps

module incremental_pid_motor_drive_top_test;
    import ipmd_pkg::*;

    localparam int POS_W        = POSITION_WIDTH_DEF;
    localparam int ACC_W        = ACC_WIDTH_DEF;
    localparam int DUTY_LIMIT   = OUTPUT_LIMIT_DEF;
    localparam int WIDE_W       = 128;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 400;

    // register index past the last coefficient, dropped by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [SETPOINT_W-1:0] SP_MAX = 32'sh7fff_ffff;
    localparam logic signed [SETPOINT_W-1:0] SP_MIN = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] COEF_MAX  = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN  = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_FINE = 32'sd1000;

    typedef struct packed {
        logic [DUTY_W-1:0]           duty;
        t_drive_dir                  drive_dir;
        logic signed [POS_OUT_W-1:0] position_now;
    } t_drive_beat;

    // drive command predictor and in-order result check
    class drive_scoreboard;
        logic signed [COEF_W-1:0] w_now;
        logic signed [COEF_W-1:0] w_prev;
        logic signed [COEF_W-1:0] w_prev2;
        logic signed [POS_W-1:0]  count_pos;
        logic signed [POS_W:0]    err_1;
        logic signed [POS_W:0]    err_2;
        logic signed [ACC_W-1:0]  acc_q16;
        t_drive_beat              pending_drive[$];
        int                       n_errors;

        function new();
            w_now     = COEF_NOW_RST;
            w_prev    = COEF_PREV_RST;
            w_prev2   = COEF_PREV2_RST;
            count_pos = '0;
            err_1     = '0;
            err_2     = '0;
            acc_q16   = '0;
            n_errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            case (idx)
                CFG_COEF_NOW:   w_now   = data;
                CFG_COEF_PREV:  w_prev  = data;
                CFG_COEF_PREV2: w_prev2 = data;
                default: ;
            endcase
        endfunction

        function void note_item(logic kind, logic dir_level,
                                logic signed [SETPOINT_W-1:0] setpoint);
            logic signed [POS_W:0]    err;
            logic signed [WIDE_W-1:0] sum;
            logic signed [WIDE_W-1:0] mag;
            logic signed [WIDE_W-1:0] acc_hi;
            logic signed [WIDE_W-1:0] acc_lo;
            t_drive_beat              beat;
            if (kind == KIND_PULSE) begin
                // encoder edge: count down when the pin is high, wrap at full width
                if (dir_level == DIR_PIN_DOWN) begin
                    count_pos = count_pos - 1;
                end else begin
                    count_pos = count_pos + 1;
                end
            end else begin
                // exact velocity-form update, then clip to the accumulator range
                err = setpoint - count_pos;
                sum = acc_q16 + w_now * err + w_prev * err_1 + w_prev2 * err_2;
                acc_hi = 1;
                acc_hi = (acc_hi <<< (ACC_W - 1)) - 1;
                acc_lo = -acc_hi - 1;
                if (sum > acc_hi) begin
                    sum = acc_hi;
                end else if (sum < acc_lo) begin
                    sum = acc_lo;
                end
                acc_q16 = sum[ACC_W-1:0];
                err_2   = err_1;
                err_1   = err;

                // integer magnitude truncated toward zero, clamped, sign as direction
                if (sum == 0) begin
                    beat.duty      = '0;
                    beat.drive_dir = DRIVE_STOP;
                end else begin
                    mag = (sum < 0) ? -sum : sum;
                    mag = mag >>> FRAC_BITS;
                    if (mag > DUTY_LIMIT) begin
                        mag = DUTY_LIMIT;
                    end
                    beat.duty = mag[DUTY_W-1:0];
                    if (sum < 0) begin
                        beat.drive_dir = DRIVE_REVERSE;
                    end else begin
                        beat.drive_dir = DRIVE_FORWARD;
                    end
                end
                beat.position_now = count_pos[POS_OUT_W-1:0];
                pending_drive.push_back(beat);
            end
        endfunction

        task check_result(t_drive_beat seen);
            t_drive_beat want;
            if (pending_drive.size() == 0) begin
                report_mismatch("result with no tick waiting", seen.position_now, 0);
            end else begin
                want = pending_drive.pop_front();
                if (seen.duty != want.duty) begin
                    report_mismatch("duty", seen.duty, want.duty);
                end
                if (seen.drive_dir != want.drive_dir) begin
                    report_mismatch("drive_dir", seen.drive_dir, want.drive_dir);
                end
                if (seen.position_now != want.position_now) begin
                    report_mismatch("position_now", seen.position_now, want.position_now);
                end
            end
        endtask

        task report_mismatch(string field, longint got, longint want);
            n_errors++;
            $display("[%0t] mismatch on %s: got %0d, expected %0d",
                     $time, field, got, want);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipmd_item_if   item_ch ();
    ipmd_result_if result_ch ();
    ipmd_cfg_if    cfg_ch ();

    drive_scoreboard sb = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off;
    int stim_pos;
    int stall_cycles = 0;

    incremental_pid_motor_drive_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    always #5 i_clk = ~i_clk;

    // result sink: random back-pressure, or a long hold-off when asked
    always @(negedge i_clk) begin
        result_ch.ready <= !hold_off && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // observe every beat at the rising edge: results first, then new items, then writes
    always @(posedge i_clk) begin
        t_drive_beat seen;
        if (i_rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                seen.duty         = result_ch.duty;
                seen.drive_dir    = result_ch.drive_dir;
                seen.position_now = result_ch.position_now;
                sb.check_result(seen);
            end
            if (item_ch.valid && item_ch.ready) begin
                sb.note_item(item_ch.kind, item_ch.direction_level, item_ch.setpoint_pulses);
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                sb.write_reg(cfg_ch.reg_index, cfg_ch.wdata);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one item, with random idle cycles ahead of it
    task automatic send_item(input logic kind, input logic dir_level,
                             input logic signed [SETPOINT_W-1:0] sp);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.kind            <= kind;
        item_ch.direction_level <= dir_level;
        item_ch.setpoint_pulses <= sp;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (kind == KIND_PULSE) begin
            stim_pos += (dir_level == DIR_PIN_DOWN) ? -1 : 1;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_weights(input logic [COEF_W-1:0] w0, input logic [COEF_W-1:0] w1,
                               input logic [COEF_W-1:0] w2);
        write_reg(CFG_COEF_NOW, w0);
        write_reg(CFG_COEF_PREV, w1);
        write_reg(CFG_COEF_PREV2, w2);
    endtask

    // stop offering, wait for every tick result, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (sb.pending_drive.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly moves: a burst of edges then a tick aimed near the count; some noise
    task automatic run_random(input int n_items);
        int                           sent;
        int                           burst;
        logic                         dir_level;
        logic signed [SETPOINT_W-1:0] sp;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                burst     = $urandom_range(0, 12);
                dir_level = 1'($urandom_range(0, 1));
                repeat (burst) begin
                    if ($urandom_range(0, 9) == 0) begin
                        dir_level = ~dir_level;
                    end
                    send_item(KIND_PULSE, dir_level, $urandom);
                end
                if ($urandom_range(0, 6) == 0) begin
                    sp = $urandom;
                end else begin
                    sp = stim_pos + int'($urandom_range(0, 800)) - 400;
                end
                send_item(KIND_TICK, 1'($urandom_range(0, 1)), sp);
                sent += burst + 1;
            end else begin
                send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n                 = 1'b0;
        item_ch.valid           = 1'b0;
        item_ch.kind            = KIND_PULSE;
        item_ch.direction_level = 1'b0;
        item_ch.setpoint_pulses = '0;
        result_ch.ready         = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.reg_index        = CFG_COEF_NOW;
        cfg_ch.wdata            = '0;
        tx_idle_pct             = 11;
        rx_idle_pct             = 80;
        hold_off                = 1'b0;
        stim_pos                = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero error straight after reset keeps the drive stopped
        send_item(KIND_TICK, 1'b0, '0);
        settle();

        // fine weight: outputs below one count still show their sign
        set_weights(COEF_FINE, '0, '0);
        write_reg(CFG_UNUSED, COEF_MAX);
        send_item(KIND_PULSE, 1'b0, SP_MAX);
        send_item(KIND_PULSE, DIR_PIN_DOWN, SP_MIN);
        send_item(KIND_PULSE, DIR_PIN_DOWN, '0);
        send_item(KIND_TICK, DIR_PIN_DOWN, '0);
        send_item(KIND_TICK, 1'b0, -32'sd3);
        send_item(KIND_TICK, 1'b0, '0);
        settle();

        // extreme weights and setpoints drive the accumulator to both rails
        set_weights(COEF_MAX, COEF_MIN, COEF_MAX);
        send_item(KIND_TICK, 1'b0, SP_MAX);
        send_item(KIND_TICK, DIR_PIN_DOWN, SP_MIN);
        send_item(KIND_TICK, 1'b0, SP_MAX);
        send_item(KIND_TICK, 1'b0, SP_MIN);
        settle();

        // unit weight times an error of 2^31 lifts the negative rail back to zero
        set_weights(COEF_ONE, '0, '0);
        send_item(KIND_TICK, 1'b0, SP_MAX);
        send_item(KIND_PULSE, 1'b0, '0);
        send_item(KIND_TICK, 1'b0, 32'sd5);
        settle();

        // slow receiver, default tuning
        set_weights(COEF_NOW_RST, COEF_PREV_RST, COEF_PREV2_RST);
        run_random(PHASE_ITEMS);
        settle();

        // slow sender, moderate random tuning
        tx_idle_pct = 80;
        rx_idle_pct = 11;
        set_weights($urandom_range(0, 1 << 24) - (1 << 23),
                    $urandom_range(0, 1 << 24) - (1 << 23),
                    $urandom_range(0, 1 << 24) - (1 << 23));
        run_random(PHASE_ITEMS);
        settle();

        // full rate, full-range tuning, with one long result hold-off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_weights($urandom, $urandom, $urandom);
        fork
            begin
                repeat (60) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        run_random(PHASE_ITEMS);
        settle();

        if (sb.n_errors == 0 && sb.pending_drive.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/ipmd_pkg.sv
design/ipmd_if.sv
design/incremental_pid_motor_drive_top.sv
design/ipmd_chk.sv
dv/incremental_pid_motor_drive_top_test.sv
